// ===== rtl/core/nmsm_pkg.sv =====
// Package for the n:m structured-sparse matrix multiply engine.
// Holds request modes, register map, widths and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nmsm_pkg;

    localparam int MAX_DIM_DEF = 16;

    localparam int CFG_W   = 5;
    localparam int VAL_W   = 16;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 38;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    typedef logic [1:0]       t_mode;
    typedef logic [REG_W-1:0] t_reg_idx;

    localparam t_mode MODE_STORE_A = 2'd0;
    localparam t_mode MODE_STORE_B = 2'd1;
    localparam t_mode MODE_COMPUTE = 2'd2;
    localparam t_mode MODE_CLEAR   = 2'd3;

    localparam t_reg_idx REG_ACTIVE = 3'd0;
    localparam t_reg_idx REG_GROUP  = 3'd1;
    localparam t_reg_idx REG_ROWS_A = 3'd2;
    localparam t_reg_idx REG_COLS_B = 3'd3;
    localparam t_reg_idx REG_INNER  = 3'd4;

    localparam logic [CFG_W-1:0] RST_ACTIVE = 5'd2;
    localparam logic [CFG_W-1:0] RST_GROUP  = 5'd4;
    localparam logic [CFG_W-1:0] RST_ROWS_A = 5'd16;
    localparam logic [CFG_W-1:0] RST_COLS_B = 5'd16;
    localparam logic [CFG_W-1:0] RST_INNER  = 5'd16;

    localparam logic [CNT_W-1:0] OPS_PER_TERM = 32'd2;
    localparam logic [CNT_W-1:0] CNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_SAT_LIM  = 32'hFFFF_FFFD;

endpackage

`default_nettype wire

// ===== rtl/core/nmsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nmsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/nm_sparse_matmul_engine_unit.sv =====
// Top level of the n:m structured-sparse matrix multiply engine.
// Depends on nmsm_pkg and nmsm_ram (one instance each for A and B).
// Clear requests and in-range store requests give no result; an out-of-range
// request gives its result strobe in the cycle after acceptance.
// A compute request holds busy while it steps k over the inner dimension, doing one
// multiply-accumulate per kept term (skipped terms are only counted), and strobes its
// result in the same cycle that busy drops.
// Results cannot be stalled. Synchronous active-low reset clears control and
// counters and restores register defaults; matrix contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nm_sparse_matmul_engine_unit #(
    parameter int MAX_DIM = nmsm_pkg::MAX_DIM_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [nmsm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [nmsm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [nmsm_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [nmsm_pkg::IDX_W-1:0]     i_row,
    input  wire logic [nmsm_pkg::IDX_W-1:0]     i_col,
    input  wire logic signed [nmsm_pkg::VAL_W-1:0] i_value,
    output logic                                o_valid,
    output logic signed [nmsm_pkg::PROD_W-1:0]  o_product,
    output logic      [nmsm_pkg::CNT_W-1:0]     o_op_count,
    output logic      [nmsm_pkg::CNT_W-1:0]     o_skip_count,
    output logic                                o_index_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = nmsm_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_active, r_group, r_rows_a, r_cols_b, r_inner;
    logic [CW-1:0] ra_lim, cb_lim, kd_lim, grp_last;

    logic [nmsm_pkg::IDX_W-1:0] r_row, n_row, r_col, n_col;
    logic [CW-1:0] r_k, n_k, r_grp, n_grp;
    logic          r_rd_vld, n_rd_vld, r_mul_vld;
    logic signed [nmsm_pkg::MUL_W-1:0]  r_mul;
    logic signed [nmsm_pkg::PROD_W-1:0] r_acc, n_acc;
    logic [nmsm_pkg::CNT_W-1:0] r_ops, n_ops, r_skip, n_skip;
    logic          r_out_vld, n_out_vld, r_err, n_err;
    logic signed [nmsm_pkg::PROD_W-1:0] r_product, n_product;

    logic           accept, cfg_wr, req_err, keep;
    logic           we_a, we_b;
    logic [AW-1:0]  waddr, raddr_a, raddr_b;
    logic [nmsm_pkg::VAL_W-1:0] rdata_a, rdata_b;
    nmsm_pkg::t_reg_idx reg_idx;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= nmsm_pkg::RST_ACTIVE;
            r_group  <= nmsm_pkg::RST_GROUP;
            r_rows_a <= nmsm_pkg::RST_ROWS_A;
            r_cols_b <= nmsm_pkg::RST_COLS_B;
            r_inner  <= nmsm_pkg::RST_INNER;
        end else if (cfg_wr) begin
            case (reg_idx)
                nmsm_pkg::REG_ACTIVE: r_active <= pwdata[CW-1:0];
                nmsm_pkg::REG_GROUP:  r_group  <= pwdata[CW-1:0];
                nmsm_pkg::REG_ROWS_A: r_rows_a <= pwdata[CW-1:0];
                nmsm_pkg::REG_COLS_B: r_cols_b <= pwdata[CW-1:0];
                nmsm_pkg::REG_INNER:  r_inner  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nmsm_pkg::REG_ACTIVE: prdata = nmsm_pkg::PDATA_W'(r_active);
            nmsm_pkg::REG_GROUP:  prdata = nmsm_pkg::PDATA_W'(r_group);
            nmsm_pkg::REG_ROWS_A: prdata = nmsm_pkg::PDATA_W'(r_rows_a);
            nmsm_pkg::REG_COLS_B: prdata = nmsm_pkg::PDATA_W'(r_cols_b);
            nmsm_pkg::REG_INNER:  prdata = nmsm_pkg::PDATA_W'(r_inner);
            default:              prdata = '0;
        endcase
    end

    // Limit sizes to the store dimension
    assign ra_lim   = (32'(r_rows_a) > MAX_DIM) ? CW'(MAX_DIM) : r_rows_a;
    assign cb_lim   = (32'(r_cols_b) > MAX_DIM) ? CW'(MAX_DIM) : r_cols_b;
    assign kd_lim   = (32'(r_inner)  > MAX_DIM) ? CW'(MAX_DIM) : r_inner;
    assign grp_last = (r_group == '0) ? '0 : r_group - CW'(1);

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        case (i_mode)
            nmsm_pkg::MODE_STORE_A:
                req_err = !((CW'(i_row) < ra_lim) && (CW'(i_col) < kd_lim));
            nmsm_pkg::MODE_STORE_B:
                req_err = !((CW'(i_row) < kd_lim) && (CW'(i_col) < cb_lim));
            default:
                req_err = !((CW'(i_row) < ra_lim) && (CW'(i_col) < cb_lim));
        endcase
    end

    assign waddr = AW'(32'(i_row) * MAX_DIM + 32'(i_col));
    assign we_a  = accept && (i_mode == nmsm_pkg::MODE_STORE_A) && !req_err;
    assign we_b  = accept && (i_mode == nmsm_pkg::MODE_STORE_B) && !req_err;

    assign raddr_a = AW'(32'(r_row) * MAX_DIM + 32'(r_k));
    assign raddr_b = AW'(32'(r_k) * MAX_DIM + 32'(r_col));
    assign keep    = (r_grp < r_active);

    nmsm_ram #(
        .WIDTH (nmsm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    nmsm_ram #(
        .WIDTH (nmsm_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        n_grp     = r_grp;
        n_rd_vld  = 1'b0;
        n_acc     = r_mul_vld ? r_acc + nmsm_pkg::PROD_W'(r_mul) : r_acc;
        n_ops     = r_ops;
        n_skip    = r_skip;
        n_out_vld = 1'b0;
        n_err     = r_err;
        n_product = r_product;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == nmsm_pkg::MODE_CLEAR) begin
                        n_ops  = '0;
                        n_skip = '0;
                    end else if (req_err) begin
                        n_out_vld = 1'b1;
                        n_err     = 1'b1;
                        n_product = '0;
                    end else if (i_mode == nmsm_pkg::MODE_COMPUTE) begin
                        n_state = S_RUN;
                        n_row   = i_row;
                        n_col   = i_col;
                        n_k     = '0;
                        n_grp   = '0;
                        n_acc   = '0;
                    end
                end
            end
            S_RUN: begin
                if (r_k == kd_lim) begin
                    n_state = S_DRAIN;
                end else begin
                    if (keep) begin
                        n_rd_vld = 1'b1;
                        n_ops    = (r_ops > nmsm_pkg::CNT_SAT_LIM) ? nmsm_pkg::CNT_MAX
                                 : r_ops + nmsm_pkg::OPS_PER_TERM;
                    end else begin
                        n_skip   = (r_skip > nmsm_pkg::CNT_SAT_LIM) ? nmsm_pkg::CNT_MAX
                                 : r_skip + nmsm_pkg::OPS_PER_TERM;
                    end
                    n_k   = r_k + CW'(1);
                    n_grp = (r_grp >= grp_last) ? '0 : r_grp + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_err     = 1'b0;
                    n_product = r_acc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_ops     <= '0;
            r_skip    <= '0;
            r_k       <= '0;
            r_grp     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_mul_vld <= r_rd_vld;
            r_out_vld <= n_out_vld;
            r_ops     <= n_ops;
            r_skip    <= n_skip;
            r_k       <= n_k;
            r_grp     <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_mul     <= $signed(rdata_a) * $signed(rdata_b);
        r_acc     <= n_acc;
        r_err     <= n_err;
        r_product <= n_product;
    end

    assign o_valid       = r_out_vld;
    assign o_product     = r_product;
    assign o_op_count    = r_ops;
    assign o_skip_count  = r_skip;
    assign o_index_error = r_err;

    a_no_result_while_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !o_valid)
        else $error("result strobe while terms are still being issued");

    a_mul_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_vld |-> $past(r_rd_vld))
        else $error("product valid without a preceding read");

    a_ops_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ops != $past(r_ops)) |-> ((r_ops == '0) || (r_ops > $past(r_ops))))
        else $error("operation counter moved backwards without a clear");

    a_drain_empty_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_DRAIN) && o_valid) |-> (!r_rd_vld && !r_mul_vld))
        else $error("compute result issued with terms still in flight");

endmodule

`default_nettype wire
